FILE: sv/three_queue_round_robin_split_defines.svh
// ----------------------------------------------------------------------------
// three_queue_round_robin_split assertion macros
// shared concurrent assertion forms, clocked on aclk, off while aresetn is low
// ----------------------------------------------------------------------------
`ifndef THREE_QUEUE_ROUND_ROBIN_SPLIT_DEFINES_SVH
`define THREE_QUEUE_ROUND_ROBIN_SPLIT_DEFINES_SVH

// condition holds at every clock edge
`define TQ_ASSERT(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define TQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

`endif

FILE: sv/tqrrs_pkg.sv
// ----------------------------------------------------------------------------
// tqrrs_pkg
// shared codes, types and defaults of the three queue round robin splitter
// ----------------------------------------------------------------------------
package tqrrs_pkg;

    // default queue depth and fixed field widths
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int NUM_QUEUES      = 3;
    localparam int DATA_W          = 32;
    localparam int MOVED_W         = 5;
    localparam logic [MOVED_W-1:0] MOVED_MAX = 5'd31;

    // command codes
    localparam logic [1:0] OP_ENQ    = 2'd0;
    localparam logic [1:0] OP_DEQ    = 2'd1;
    localparam logic [1:0] OP_REDIST = 2'd2;
    localparam logic [1:0] OP_RSVD   = 2'd3;

    // queue select codes
    localparam logic [1:0] Q_ONE   = 2'd0;
    localparam logic [1:0] Q_TWO   = 2'd1;
    localparam logic [1:0] Q_THREE = 2'd2;
    localparam logic [1:0] Q_NONE  = 2'd3;

    // result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_EMPTY   = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;
    localparam logic [1:0] STAT_INVALID = 2'd3;

    // control sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_REDIST,
        S_DONE
    } state_t;

    // store port strobes
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

endpackage

FILE: sv/tqrrs_store.sv
// ----------------------------------------------------------------------------
// tqrrs_store
// shared queue storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module tqrrs_store #(
    parameter int QUEUE_DEPTH = tqrrs_pkg::QUEUE_DEPTH_DEF,
    parameter int WORDS       = tqrrs_pkg::NUM_QUEUES * QUEUE_DEPTH,
    parameter int ADDR_W      = $clog2(WORDS)
) (
    input  logic                          aclk,
    input  tqrrs_pkg::mem_ctl_t           mem_ctl,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  logic [tqrrs_pkg::DATA_W-1:0]  wr_data,
    input  logic [ADDR_W-1:0]             rd_addr,
    output logic [tqrrs_pkg::DATA_W-1:0]  rd_data
);
    import tqrrs_pkg::*;

    logic [DATA_W-1:0] mem [WORDS];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (mem_ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (mem_ctl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/tqrrs_ctrl.sv
// ----------------------------------------------------------------------------
// tqrrs_ctrl
// command sequencer, queue pointers and fill counts, result register
// ----------------------------------------------------------------------------
`include "three_queue_round_robin_split_defines.svh"

module tqrrs_ctrl #(
    parameter int QUEUE_DEPTH = tqrrs_pkg::QUEUE_DEPTH_DEF,
    parameter int ADDR_W      = $clog2(tqrrs_pkg::NUM_QUEUES * QUEUE_DEPTH)
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_op,
    input  logic [1:0]                     s_queue_sel,
    input  logic signed [tqrrs_pkg::DATA_W-1:0] s_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [tqrrs_pkg::DATA_W-1:0] m_data_out,
    output logic [1:0]                     m_status,
    output logic [tqrrs_pkg::MOVED_W-1:0]  m_moved_count,
    output tqrrs_pkg::mem_ctl_t            mem_ctl,
    output logic [ADDR_W-1:0]              wr_addr,
    output logic [tqrrs_pkg::DATA_W-1:0]   wr_data,
    output logic [ADDR_W-1:0]              rd_addr,
    input  logic [tqrrs_pkg::DATA_W-1:0]   rd_data
);
    import tqrrs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   head_reg [NUM_QUEUES];
    logic [PTR_W-1:0]   head_next [NUM_QUEUES];
    logic [CNT_W-1:0]   fill_reg [NUM_QUEUES];
    logic [CNT_W-1:0]   fill_next [NUM_QUEUES];
    logic               tgt_reg, tgt_next;
    logic [MOVED_W-1:0] moved_reg, moved_next;
    logic [DATA_W-1:0]  res_data_reg, res_data_next;
    logic [1:0]         res_stat_reg, res_stat_next;
    logic               res_mem_reg, res_mem_next;
    logic               wr_pend_reg, wr_pend_next;
    logic [ADDR_W-1:0]  wr_addr_reg, wr_addr_next;
    logic               m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]  m_data_reg, m_data_next;
    logic [1:0]         m_stat_reg, m_stat_next;
    logic [MOVED_W-1:0] m_moved_reg, m_moved_next;
    logic [1:0]         tgt_q;
    logic               out_free;
    logic               redist_stop;

    // slot after the last item of a queue
    function automatic logic [PTR_W-1:0] tail_slot(input logic [PTR_W-1:0] h,
                                                   input logic [CNT_W-1:0] f);
        logic [SUM_W-1:0] s;
        s = SUM_W'(h) + SUM_W'(f);
        if (s >= SUM_W'(QUEUE_DEPTH)) begin
            s = s - SUM_W'(QUEUE_DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    // head advance with wrap
    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] h);
        logic [PTR_W-1:0] n;
        if (h == PTR_W'(QUEUE_DEPTH - 1)) begin
            n = '0;
        end else begin
            n = h + PTR_W'(1);
        end
        return n;
    endfunction

    // store address of a queue slot
    function automatic logic [ADDR_W-1:0] addr_of(input logic [1:0] q,
                                                  input logic [PTR_W-1:0] slot);
        logic [ADDR_W-1:0] base;
        unique case (q)
            Q_ONE:   base = '0;
            Q_TWO:   base = ADDR_W'(QUEUE_DEPTH);
            Q_THREE: base = ADDR_W'(2 * QUEUE_DEPTH);
            default: base = '0;
        endcase
        return base + ADDR_W'(slot);
    endfunction

    assign tgt_q       = tgt_reg ? Q_THREE : Q_TWO;
    assign out_free    = !m_valid_reg || m_ready;
    assign redist_stop = (fill_reg[0] == '0) || (fill_reg[tgt_q] == FULL_CNT);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = (s_op == OP_REDIST) ? S_REDIST : S_DONE;
                end
            end
            S_REDIST: begin
                if (redist_stop) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and store access
    always_comb begin
        head_next     = head_reg;
        fill_next     = fill_reg;
        tgt_next      = tgt_reg;
        moved_next    = moved_reg;
        res_data_next = res_data_reg;
        res_stat_next = res_stat_reg;
        res_mem_next  = res_mem_reg;
        wr_pend_next  = 1'b0;
        wr_addr_next  = wr_addr_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        m_stat_next   = m_stat_reg;
        m_moved_next  = m_moved_reg;
        mem_ctl       = '0;
        wr_addr       = wr_addr_reg;
        wr_data       = rd_data;
        rd_addr       = '0;

        // second half of a move: write the item just read from queue one
        if (wr_pend_reg) begin
            mem_ctl.wr_en = 1'b1;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    res_data_next = '0;
                    res_stat_next = STAT_OK;
                    res_mem_next  = 1'b0;
                    moved_next    = '0;
                    tgt_next      = 1'b0;
                    unique case (s_op)
                        OP_ENQ: begin
                            if (fill_reg[0] == FULL_CNT) begin
                                res_stat_next = STAT_FULL;
                            end else begin
                                mem_ctl.wr_en = 1'b1;
                                wr_addr       = addr_of(Q_ONE,
                                                    tail_slot(head_reg[0], fill_reg[0]));
                                wr_data       = s_value;
                                fill_next[0]  = fill_reg[0] + CNT_W'(1);
                                res_data_next = s_value;
                            end
                        end
                        OP_DEQ: begin
                            if (s_queue_sel == Q_NONE) begin
                                res_stat_next = STAT_INVALID;
                            end else if (fill_reg[s_queue_sel] == '0) begin
                                res_stat_next = STAT_EMPTY;
                            end else begin
                                mem_ctl.rd_en = 1'b1;
                                rd_addr       = addr_of(s_queue_sel, head_reg[s_queue_sel]);
                                head_next[s_queue_sel] = next_ptr(head_reg[s_queue_sel]);
                                fill_next[s_queue_sel] = fill_reg[s_queue_sel] - CNT_W'(1);
                                res_mem_next  = 1'b1;
                            end
                        end
                        OP_REDIST: begin
                        end
                        OP_RSVD: begin
                            res_stat_next = STAT_INVALID;
                        end
                        default: res_stat_next = STAT_INVALID;
                    endcase
                end
            end
            S_REDIST: begin
                if (fill_reg[0] == '0) begin
                    res_stat_next = STAT_OK;
                end else if (fill_reg[tgt_q] == FULL_CNT) begin
                    res_stat_next = STAT_FULL;
                end else begin
                    // pop queue one, reserve the slot in the target queue
                    mem_ctl.rd_en    = 1'b1;
                    rd_addr          = addr_of(Q_ONE, head_reg[0]);
                    head_next[0]     = next_ptr(head_reg[0]);
                    fill_next[0]     = fill_reg[0] - CNT_W'(1);
                    wr_pend_next     = 1'b1;
                    wr_addr_next     = addr_of(tgt_q, tail_slot(head_reg[tgt_q],
                                                                fill_reg[tgt_q]));
                    fill_next[tgt_q] = fill_reg[tgt_q] + CNT_W'(1);
                    tgt_next         = !tgt_reg;
                    if (moved_reg != MOVED_MAX) begin
                        moved_next = moved_reg + MOVED_W'(1);
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_mem_reg ? rd_data : res_data_reg;
                    m_stat_next  = res_stat_reg;
                    m_moved_next = moved_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            wr_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            wr_pend_reg <= wr_pend_next;
            m_valid_reg <= m_valid_next;
            head_reg    <= head_next;
            fill_reg    <= fill_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        tgt_reg      <= tgt_next;
        moved_reg    <= moved_next;
        res_data_reg <= res_data_next;
        res_stat_reg <= res_stat_next;
        res_mem_reg  <= res_mem_next;
        wr_addr_reg  <= wr_addr_next;
        m_data_reg   <= m_data_next;
        m_stat_reg   <= m_stat_next;
        m_moved_reg  <= m_moved_next;
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_data_out    = m_data_reg;
    assign m_status      = m_stat_reg;
    assign m_moved_count = m_moved_reg;

    // checks
    `TQ_ASSERT(a_fill_bound, (fill_reg[0] <= FULL_CNT) && (fill_reg[1] <= FULL_CNT) && (fill_reg[2] <= FULL_CNT), "queue fill count beyond depth")
    `TQ_ASSERT_IMP(a_pend_busy, wr_pend_reg, state_reg != S_IDLE, "move write pending while idle")
    `TQ_ASSERT_IMP(a_redist_src, (state_reg == S_REDIST) && mem_ctl.rd_en, fill_reg[0] != '0, "move read from empty queue one")
    `TQ_ASSERT_IMP(a_fail_zero, m_valid_reg && (m_stat_reg != STAT_OK), m_data_reg == '0, "failed command returns data")

endmodule

FILE: sv/three_queue_round_robin_split.sv
// ----------------------------------------------------------------------------
// three_queue_round_robin_split
// three bounded FIFO queues with enqueue, dequeue and round robin split
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the s_ channel (s_op, s_queue_sel, s_value) under
//   valid/ready; each command gives exactly one result item on the m_ channel
//   (m_data_out, m_status, m_moved_count). One command is worked at a time.
//   Enqueue and dequeue pass through the accept cycle, which touches the
//   shared store, and the S_DONE state, which loads the output register
//   once it is free. A redistribute command passes through the accept
//   cycle, the move loop in S_REDIST, a final S_REDIST check that ends the
//   loop while the last write lands, and the output load in S_DONE. The store
//   has one read and one write port, so the move loop reads one item from
//   queue one per cycle and writes it into queue two or three in the
//   following cycle. A new command is taken only once the last result has
//   entered the output register. s_ready is high whenever the sequencer is
//   idle. When the receiver stalls, the result holds in the output register;
//   the next command is still taken and worked, and its result waits with s_ready low. Reset
//   (aresetn low at a clock edge) empties all three queues at once.
// ----------------------------------------------------------------------------
module three_queue_round_robin_split #(
    parameter int QUEUE_DEPTH = tqrrs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_op,
    input  logic [1:0]                          s_queue_sel,
    input  logic signed [tqrrs_pkg::DATA_W-1:0] s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [tqrrs_pkg::DATA_W-1:0] m_data_out,
    output logic [1:0]                          m_status,
    output logic [tqrrs_pkg::MOVED_W-1:0]       m_moved_count
);
    import tqrrs_pkg::*;

    localparam int WORDS  = NUM_QUEUES * QUEUE_DEPTH;
    localparam int ADDR_W = $clog2(WORDS);

    mem_ctl_t          mem_ctl;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_W-1:0] wr_data;
    logic [DATA_W-1:0] rd_data;

    // sequencer
    tqrrs_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_queue_sel   (s_queue_sel),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data_out    (m_data_out),
        .m_status      (m_status),
        .m_moved_count (m_moved_count),
        .mem_ctl       (mem_ctl),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data)
    );

    // queue storage
    tqrrs_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .WORDS       (WORDS),
        .ADDR_W      (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .mem_ctl (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule
